// ----- sv/rsw_pkg.sv -----
// shared types, constants and the quarter-wave sine function of the ripple generator
`timescale 1ns / 1ps
`default_nettype none
package rsw_pkg;

   localparam int MAX_SIDE_DEF    = 2048;
   localparam int SINE_DEPTH_DEF  = 1024;
   localparam int FRAC_BITS_DEF   = 10;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SIDE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XSHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YSHIFT = 2'd2;

   localparam logic [11:0] SIDE_RESET = 12'd256;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue_level;
   } rsp_payload_type;

   // sin(k*pi/(2*depth)) in q30, odd taylor series to 9th order, truncating steps
   function automatic logic [30:0] quarter_sine(input longint unsigned k,
                                                input int depth_log2);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned a;
      longint unsigned b;
      longint unsigned c;
      longint unsigned d;
      longint unsigned s;
      x  = (k * HALF_PI_Q30) >> depth_log2;
      x2 = (x * x) >> 30;
      a  = Q30_ONE - x2 / 72;
      b  = Q30_ONE - ((x2 * a) >> 30) / 42;
      c  = Q30_ONE - ((x2 * b) >> 30) / 20;
      d  = Q30_ONE - ((x2 * c) >> 30) / 6;
      s  = (x * d) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return s[30:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/rsw_stream_if.sv -----
// valid/ready stream interface carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface rsw_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/rsw_sqrt_cell.sv -----
// one cell of the square root chain: settles one root bit per beat
`timescale 1ns / 1ps
`default_nettype none
module rsw_sqrt_cell #(
   parameter int RW = 50,
   parameter int NC = 25
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire logic          in_valid,
   input  wire logic [RW-1:0] in_rad,
   input  wire logic [NC:0]   in_rem,
   input  wire logic [NC-1:0] in_root,
   output      logic          out_valid,
   output      logic [RW-1:0] out_rad,
   output      logic [NC:0]   out_rem,
   output      logic [NC-1:0] out_root
);

   logic          valid_ff;
   logic [RW-1:0] rad_ff;
   logic [NC:0]   rem_ff;
   logic [NC-1:0] root_ff;
   logic [NC:0]   rem_in;
   logic [NC-1:0] root_in;
   logic [NC+2:0] rem2;
   logic [NC+2:0] trial;
   logic [NC+2:0] diff;

   always_comb begin
      rem2  = {in_rem, in_rad[RW-1:RW-2]};
      trial = {1'b0, in_root, 2'b01};
      diff  = rem2 - trial;
      if (rem2 >= trial) begin
         rem_in  = diff[NC:0];
         root_in = {in_root[NC-2:0], 1'b1};
      end else begin
         rem_in  = rem2[NC:0];
         root_in = {in_root[NC-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rad_ff  <= {in_rad[RW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

   // remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rem_ff <= {root_ff, 1'b0}))
      else $error("sqrt cell remainder out of bound");

endmodule
`default_nettype wire

// ----- sv/radial_sine_wave_pixel.sv -----
// top level of the radial ripple pattern generator
// Radial ripple generator: each beat on req_ch carries a pixel (pixel_x, pixel_y) and
// yields one beat on rsp_ch with blue_level = floor(127.5*(sin(d)+1)), d being the
// distance in pixels to the centre (side/2 + x shift, side/2 + y shift).
// One pixel is taken every clock while rsp_ch is ready. The square root chain spends
// one cell per root bit. A side above MAX_SIDE is saturated. SINE_TABLE_DEPTH must
// be a power of two; the quarter-wave rom read is registered before the output register.
// csr_* writes take effect at once and are only to be made while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none
module radial_sine_wave_pixel #(
   parameter int MAX_SIDE         = rsw_pkg::MAX_SIDE_DEF,
   parameter int SINE_TABLE_DEPTH = rsw_pkg::SINE_DEPTH_DEF,
   parameter int FRAC_BITS        = rsw_pkg::FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [rsw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rsw_pkg::CSR_DATA_W-1:0] csr_wdata,
   rsw_stream_if.sink                          req_ch,
   rsw_stream_if.source                        rsp_ch
);

   // widths
   localparam int SSW = $clog2(MAX_SIDE + 1);
   localparam int SCW = (SSW > 12) ? SSW : 12;
   localparam int DXW = $clog2(MAX_SIDE + 8191) + 1;   // half-pixel offset, signed
   localparam int SQW = 2 * DXW - 1;                    // one square
   localparam int SMW = 2 * DXW;                        // sum of squares
   localparam int RW  = SMW + 2 * FRAC_BITS;            // radicand
   localparam int NC  = DXW + FRAC_BITS;                // root bits = cells
   localparam int DW  = NC - 1;                         // distance width
   localparam int HW  = (DW + 1) / 2;
   localparam int HIW = DW - HW;
   localparam int PW  = DW + 30;
   localparam int LD  = $clog2(SINE_TABLE_DEPTH);
   localparam int L   = LD + 2;
   localparam int AW  = LD + 1;

   typedef logic [30:0] rom_type [0:SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t[k] = rsw_pkg::quarter_sine(longint'(k), LD);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration registers
   logic [11:0] side_ff;
   logic [11:0] xoff_ff;
   logic [11:0] yoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= rsw_pkg::SIDE_RESET;
         xoff_ff <= '0;
         yoff_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rsw_pkg::CSR_SIDE:   side_ff <= csr_wdata;
            rsw_pkg::CSR_XSHIFT: xoff_ff <= csr_wdata;
            rsw_pkg::CSR_YSHIFT: yoff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipe moves when the output register is free or being drained
   logic adv;
   logic v_out_ff;
   assign adv          = !v_out_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 1: offsets from the centre in half pixels
   logic [SCW-1:0]        side_cmp;
   logic [SCW-1:0]        side_sat;
   logic signed [DXW-1:0] side_ext;
   logic signed [DXW-1:0] xoff2;
   logic signed [DXW-1:0] yoff2;
   logic signed [DXW-1:0] px2;
   logic signed [DXW-1:0] py2;
   logic signed [DXW-1:0] dx_in;
   logic signed [DXW-1:0] dy_in;
   logic signed [DXW-1:0] dx_ff;
   logic signed [DXW-1:0] dy_ff;
   logic                  v_d_ff;

   always_comb begin
      side_cmp = SCW'(side_ff);
      side_sat = (side_cmp > SCW'(MAX_SIDE)) ? SCW'(MAX_SIDE) : side_cmp;
      side_ext = $signed({{(DXW-SCW){1'b0}}, side_sat});
      xoff2    = $signed({{(DXW-13){xoff_ff[11]}}, xoff_ff, 1'b0});
      yoff2    = $signed({{(DXW-13){yoff_ff[11]}}, yoff_ff, 1'b0});
      px2      = $signed({{(DXW-12){1'b0}}, req_ch.data.pixel_x, 1'b0});
      py2      = $signed({{(DXW-12){1'b0}}, req_ch.data.pixel_y, 1'b0});
      dx_in    = px2 - side_ext - xoff2;
      dy_in    = py2 - side_ext - yoff2;
   end

   // stage 2: squares, stage 3: their sum
   logic signed [2*DXW-1:0] sqx_full;
   logic signed [2*DXW-1:0] sqy_full;
   logic [SQW-1:0]          sqx_ff;
   logic [SQW-1:0]          sqy_ff;
   logic                    v_sq_ff;
   logic [SMW-1:0]          sum_ff;
   logic                    v_sum_ff;

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_d_ff   <= 1'b0;
         v_sq_ff  <= 1'b0;
         v_sum_ff <= 1'b0;
      end else if (adv) begin
         v_d_ff   <= req_ch.valid;
         v_sq_ff  <= v_d_ff;
         v_sum_ff <= v_sq_ff;
      end
      if (adv) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         sqx_ff <= sqx_full[SQW-1:0];
         sqy_ff <= sqy_full[SQW-1:0];
         sum_ff <= SMW'(sqx_ff) + SMW'(sqy_ff);
      end
   end

   // square root chain: one cell per root bit
   logic          c_valid [0:NC];
   logic [RW-1:0] c_rad   [0:NC];
   logic [NC:0]   c_rem   [0:NC];
   logic [NC-1:0] c_root  [0:NC];

   assign c_valid[0] = v_sum_ff;
   assign c_rad[0]   = {sum_ff, {(2*FRAC_BITS){1'b0}}};
   assign c_rem[0]   = '0;
   assign c_root[0]  = '0;

   for (genvar g = 0; g < NC; g++) begin : g_cell
      rsw_sqrt_cell #(.RW(RW), .NC(NC)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .in_valid  (c_valid[g]),
         .in_rad    (c_rad[g]),
         .in_rem    (c_rem[g]),
         .in_root   (c_root[g]),
         .out_valid (c_valid[g+1]),
         .out_rad   (c_rad[g+1]),
         .out_rem   (c_rem[g+1]),
         .out_root  (c_root[g+1])
      );
   end

   // distance in pixels with FRAC_BITS fraction bits, root is in half pixels
   logic [DW-1:0] radius;
   assign radius = c_root[NC][NC-1:1];

   // phase in turns: distance times 1/(2*pi), split in two partial products
   logic [HW+29:0]  plo_ff;
   logic [HIW+29:0] phi_ff;
   logic            v_p_ff;
   logic [PW-1:0]   prod;
   logic [31:0]     turns_ff;
   logic            v_t_ff;

   assign prod = PW'(plo_ff) + (PW'(phi_ff) << HW);

   // table index rounded to nearest, wrap drops the carry
   logic [32:0]   rnd;
   logic [L-1:0]  idx;
   logic [AW-1:0] addr_in;
   logic [AW-1:0] addr_ff;
   logic [1:0]    quad_a_ff;
   logic          v_a_ff;

   always_comb begin
      rnd = 33'(turns_ff) + 33'(64'd1 << (31 - L));
      idx = rnd[31:32-L];
      if (idx[L-2]) begin
         addr_in = AW'(SINE_TABLE_DEPTH) - AW'(idx[LD-1:0]);
      end else begin
         addr_in = AW'(idx[LD-1:0]);
      end
   end

   // rom read and output
   logic [30:0] mag_ff;
   logic [1:0]  quad_r_ff;
   logic        v_r_ff;
   logic [31:0] level;
   logic [39:0] scaled;
   logic [8:0]  blue_raw;
   logic [7:0]  blue_in;
   rsw_pkg::rsp_payload_type rsp_ff;

   always_comb begin
      if (quad_r_ff[1]) begin
         level = 32'(rsw_pkg::Q30_ONE) - 32'(mag_ff);
      end else begin
         level = 32'(rsw_pkg::Q30_ONE) + 32'(mag_ff);
      end
      scaled   = {level, 8'b0} - 40'(level);
      blue_raw = scaled[39:31];
      blue_in  = (blue_raw > 9'd255) ? 8'd255 : blue_raw[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff   <= 1'b0;
         v_t_ff   <= 1'b0;
         v_a_ff   <= 1'b0;
         v_r_ff   <= 1'b0;
         v_out_ff <= 1'b0;
      end else if (adv) begin
         v_p_ff   <= c_valid[NC];
         v_t_ff   <= v_p_ff;
         v_a_ff   <= v_t_ff;
         v_r_ff   <= v_a_ff;
         v_out_ff <= v_r_ff;
      end
      if (adv) begin
         plo_ff    <= (HW+30)'(radius[HW-1:0]) * (HW+30)'(rsw_pkg::INV_TWO_PI_Q32);
         phi_ff    <= (HIW+30)'(radius[DW-1:HW]) * (HIW+30)'(rsw_pkg::INV_TWO_PI_Q32);
         turns_ff  <= prod[FRAC_BITS+31:FRAC_BITS];
         addr_ff   <= addr_in;
         quad_a_ff <= idx[L-1:L-2];
         mag_ff    <= SINE_ROM[addr_ff];
         quad_r_ff <= quad_a_ff;
         rsp_ff.blue_level <= blue_in;
      end
   end

   assign rsp_ch.valid = v_out_ff;
   assign rsp_ch.data  = rsp_ff;

   // rom address stays inside the quarter wave
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      v_a_ff |-> (addr_ff <= AW'(SINE_TABLE_DEPTH)))
      else $error("sine rom address beyond quarter wave");

   // upper half wave never gives a level below mid scale
   a_upper_half: assert property (@(posedge clock) disable iff (reset)
      (adv && v_r_ff && !quad_r_ff[1]) |=> (rsp_ch.data.blue_level >= 8'd127))
      else $error("positive sine gave low blue level");

   // lower half wave never gives a level above mid scale
   a_lower_half: assert property (@(posedge clock) disable iff (reset)
      (adv && v_r_ff && quad_r_ff[1]) |=> (rsp_ch.data.blue_level <= 8'd127))
      else $error("negative sine gave high blue level");

endmodule
`default_nettype wire
